// ----- sv/positional_list_store_defines.svh -----
// ---------------------------------------------------------------------------
// Positional list store assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define PLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pls_pkg.sv -----
// ---------------------------------------------------------------------------
// Positional list store package
// Sizes, request and result types, sequencer states and control groups.
// ---------------------------------------------------------------------------
package pls_pkg;

    localparam int CAPACITY = 256;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 9;
    localparam int LEN_W    = 9;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        action_t                   action;
        logic [POS_W-1:0]          position;
        logic signed [VAL_W-1:0]   value;
    } request_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VAL_W-1:0]   read_value;
        logic [LEN_W-1:0]          length;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_LINK_A,
        S_LINK_B,
        S_UNLINK,
        S_READ_OUT
    } state_t;

    // Status the datapath hands to the sequencer.
    typedef struct packed {
        logic    start;
        action_t req_action;
        action_t cur_action;
        logic    pos_bad;
        logic    full;
        logic    walk_done;
    } seq_flags_t;

    // Strobes the sequencer hands to the datapath.
    typedef struct packed {
        logic accept;
        logic clear;
        logic reject;
        logic alloc;
        logic walk_init;
        logic walk_step;
        logic walk_end;
        logic link_a;
        logic link_b;
        logic unlink;
        logic read_out;
    } ctrl_t;

endpackage

// ----- sv/pls_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/pls_seq.sv -----
// ---------------------------------------------------------------------------
// Positional list store sequencer
// Steps one request through allocation, the link walk and relinking.
// ---------------------------------------------------------------------------
module pls_seq import pls_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ctrl_t      ctrl,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (flags.start)
                begin
                    case (flags.req_action)
                        ACT_INSERT: state_next = (flags.pos_bad || flags.full) ? S_IDLE : S_ALLOC;
                        ACT_REMOVE: state_next = flags.pos_bad ? S_IDLE : S_WALK;
                        ACT_READ:   state_next = flags.pos_bad ? S_IDLE : S_WALK;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ALLOC:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (flags.walk_done)
                begin
                    case (flags.cur_action)
                        ACT_INSERT: state_next = S_LINK_A;
                        ACT_REMOVE: state_next = S_UNLINK;
                        default:    state_next = S_READ_OUT;
                    endcase
                end
            end
            S_LINK_A:
            begin
                state_next = S_LINK_B;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl        = '0;
        ctrl.accept = (state_reg == S_IDLE) && flags.start;
        ctrl.clear  = ctrl.accept && (flags.req_action == ACT_CLEAR);
        ctrl.reject = ctrl.accept && (flags.req_action != ACT_CLEAR)
                      && (flags.pos_bad || ((flags.req_action == ACT_INSERT) && flags.full));
        ctrl.alloc  = (state_reg == S_ALLOC);
        ctrl.walk_init = ctrl.alloc
                         || (ctrl.accept && !flags.pos_bad
                             && ((flags.req_action == ACT_REMOVE)
                                 || (flags.req_action == ACT_READ)));
        ctrl.walk_step = (state_reg == S_WALK) && !flags.walk_done;
        ctrl.walk_end  = (state_reg == S_WALK) && flags.walk_done;
        ctrl.link_a    = (state_reg == S_LINK_A);
        ctrl.link_b    = (state_reg == S_LINK_B);
        ctrl.unlink    = (state_reg == S_UNLINK);
        ctrl.read_out  = (state_reg == S_READ_OUT);
        busy           = (state_reg != S_IDLE);
    end

endmodule

// ----- sv/positional_list_store.sv -----
// ---------------------------------------------------------------------------
// Positional list store
// Bounded ordered list of signed 32-bit values kept as a circular doubly
// linked ring over a fixed pool of slots, addressed by position.
// ---------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low. Clear
// and every rejected request (position out of range, or insert into a full
// list) finish at once: busy never rises and the result strobe done comes
// in the next cycle. Other requests walk the ring from the head, one link
// per cycle through the single read port of the next-link memory, so the
// walk takes one link step per position (none for an append at the end).
// Busy then stays high through the walk and the unlink or read-out step on
// a remove or read, and through the free-slot fetch, the walk and the
// first and second relink steps on an insert. The longest request is an
// insert at position 254 into a list of 255 elements. The result is on
// the result port for exactly one cycle with done high, and the receiver
// cannot hold it off; a new request may be started in that same cycle.
// There is no clearing pass after reset: the free-slot stack is tracked by
// a low-water mark, so the block takes requests right after reset.
// ---------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module positional_list_store import pls_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    // List bookkeeping. The free stack holds its free slots in entries
    // below top = CAPACITY - count. The low-water mark is the smallest top
    // seen since the last clear; free entries at or above it were written by
    // a push, entries below it are unwritten and stand for their own index.
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  wmark_reg, wmark_next;

    // Request being worked on.
    action_t                 act_reg, act_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;

    // Walk and relink working registers: s is the new slot, t the target
    // slot found by the walk, p the slot before the target.
    logic [SLOT_W-1:0] s_reg, s_next;
    logic [SLOT_W-1:0] t_reg, t_next;
    logic [SLOT_W-1:0] p_reg, p_next;
    logic [POS_W-1:0]  remain_reg, remain_next;
    logic              first_reg, first_next;

    logic    done_reg, done_next;
    result_t result_reg, result_next;

    // Memory ports.
    logic              elem_we;
    logic [SLOT_W-1:0] elem_waddr;
    logic [VAL_W-1:0]  elem_wdata;
    logic [VAL_W-1:0]  elem_rd;
    logic              next_we;
    logic [SLOT_W-1:0] next_waddr;
    logic [SLOT_W-1:0] next_wdata;
    logic [SLOT_W-1:0] next_rd;
    logic              prev_we;
    logic [SLOT_W-1:0] prev_waddr;
    logic [SLOT_W-1:0] prev_wdata;
    logic [SLOT_W-1:0] prev_rd;
    logic              free_we;
    logic [SLOT_W-1:0] free_waddr;
    logic [SLOT_W-1:0] free_wdata;
    logic [SLOT_W-1:0] free_raddr;
    logic [SLOT_W-1:0] free_rd;

    logic [CNT_W-1:0]  top_c;
    logic [CNT_W-1:0]  top_after;
    logic              pos_bad;
    logic              full;
    logic              pos_lt_reg;
    logic              walk_done;
    logic [SLOT_W-1:0] walk_slot;
    logic [SLOT_W-1:0] p_sel;

    seq_flags_t flags;
    ctrl_t      ctrl;

    // Range checks against the current length. Insert may target the
    // position just past the end; remove and read may not.
    assign top_c     = CNT_W'(CAPACITY) - count_reg;
    assign top_after = top_c - CNT_W'(1);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign pos_bad   = (request.action == ACT_INSERT)
                       ? (CMP_W'(request.position) >  CMP_W'(count_reg))
                       : (CMP_W'(request.position) >= CMP_W'(count_reg));
    assign pos_lt_reg = (CMP_W'(pos_reg) < CMP_W'(count_reg));
    assign walk_done  = (remain_reg == '0);

    // The walk feeds each next-link read straight back as the next address,
    // which gives one link per cycle. The first step starts at the head.
    assign walk_slot  = first_reg ? head_reg : next_rd;
    assign free_raddr = SLOT_W'(top_after);

    // The slot before the target. An insert into an empty list links the
    // new slot to itself, and the prev link read at the walk end is unused.
    assign p_sel = (count_reg == '0) ? s_reg : prev_rd;

    always_comb
    begin
        flags.start      = start;
        flags.req_action = request.action;
        flags.cur_action = act_reg;
        flags.pos_bad    = pos_bad;
        flags.full       = full;
        flags.walk_done  = walk_done;
    end

    pls_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    pls_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (walk_slot),
        .rdata (elem_rd)
    );

    pls_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (walk_slot),
        .rdata (next_rd)
    );

    pls_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (walk_slot),
        .rdata (prev_rd)
    );

    pls_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rd)
    );

    always_comb
    begin
        count_next  = count_reg;
        head_next   = head_reg;
        wmark_next  = wmark_reg;
        act_next    = act_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        s_next      = s_reg;
        t_next      = t_reg;
        p_next      = p_reg;
        remain_next = remain_reg;
        first_next  = first_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        elem_we    = 1'b0;
        elem_waddr = s_reg;
        elem_wdata = val_reg;
        next_we    = 1'b0;
        next_waddr = s_reg;
        next_wdata = t_reg;
        prev_we    = 1'b0;
        prev_waddr = s_reg;
        prev_wdata = p_sel;
        free_we    = 1'b0;
        free_waddr = SLOT_W'(top_c);
        free_wdata = t_reg;

        if (ctrl.accept)
        begin
            act_next = request.action;
            pos_next = request.position;
            val_next = request.value;
        end

        // Clear puts the free stack, head and length back to their reset state.
        if (ctrl.clear)
        begin
            count_next             = '0;
            head_next              = '0;
            wmark_next             = CNT_W'(CAPACITY);
            done_next              = 1'b1;
            result_next.status     = ST_DONE;
            result_next.read_value = '0;
            result_next.length     = '0;
        end

        // The position check comes before the fullness check on an insert.
        if (ctrl.reject)
        begin
            done_next              = 1'b1;
            result_next.status     = ((request.action == ACT_INSERT) && !pos_bad)
                                     ? ST_FULL : ST_RANGE;
            result_next.read_value = '0;
            result_next.length     = LEN_W'(count_reg);
        end

        // Pop the free stack: untouched entries stand for their own index.
        if (ctrl.alloc)
        begin
            s_next = (top_c == wmark_reg) ? SLOT_W'(top_after) : free_rd;
        end

        // An append walks zero steps and lands on the head, which is the
        // slot that follows the tail in the ring.
        if (ctrl.walk_init)
        begin
            first_next  = 1'b1;
            remain_next = ctrl.alloc ? (pos_lt_reg ? pos_reg : '0) : request.position;
        end

        if (ctrl.walk_step)
        begin
            first_next  = 1'b0;
            remain_next = remain_reg - POS_W'(1);
        end

        if (ctrl.walk_end)
        begin
            t_next = (count_reg == '0) ? s_reg : walk_slot;
        end

        // Insert, first half: fill the new slot and point it at its neighbors.
        if (ctrl.link_a)
        begin
            p_next     = p_sel;
            elem_we    = 1'b1;
            next_we    = 1'b1;
            prev_we    = 1'b1;
        end

        // Insert, second half: point the neighbors at the new slot.
        if (ctrl.link_b)
        begin
            next_we    = 1'b1;
            next_waddr = p_reg;
            next_wdata = s_reg;
            prev_we    = 1'b1;
            prev_waddr = t_reg;
            prev_wdata = s_reg;
            if (pos_reg == '0)
            begin
                head_next = s_reg;
            end
            if (top_after < wmark_reg)
            begin
                wmark_next = top_after;
            end
            count_next             = count_reg + CNT_W'(1);
            done_next              = 1'b1;
            result_next.status     = ST_DONE;
            result_next.read_value = '0;
            result_next.length     = LEN_W'(count_reg + CNT_W'(1));
        end

        // Remove: bridge the neighbors of the target and push it on the
        // free stack. A lone element leaves the ring with nothing to bridge.
        if (ctrl.unlink)
        begin
            if (count_reg > CNT_W'(1))
            begin
                next_we    = 1'b1;
                next_waddr = prev_rd;
                next_wdata = next_rd;
                prev_we    = 1'b1;
                prev_waddr = next_rd;
                prev_wdata = prev_rd;
                if (pos_reg == '0)
                begin
                    head_next = next_rd;
                end
            end
            free_we                = 1'b1;
            count_next             = count_reg - CNT_W'(1);
            done_next              = 1'b1;
            result_next.status     = ST_DONE;
            result_next.read_value = '0;
            result_next.length     = LEN_W'(count_reg - CNT_W'(1));
        end

        if (ctrl.read_out)
        begin
            done_next              = 1'b1;
            result_next.status     = ST_DONE;
            result_next.read_value = elem_rd;
            result_next.length     = LEN_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            wmark_reg <= CNT_W'(CAPACITY);
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            wmark_reg <= wmark_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        p_reg      <= p_next;
        remain_reg <= remain_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The length never passes the pool size, and the low-water mark never
    // rises above the current stack top.
    `PLS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "length beyond capacity")
    `PLS_ASSERT_NOW(a_wmark_bound, 1'b1, wmark_reg <= top_c, "free-stack mark above stack top")
    // A request that does not finish at once keeps the block busy.
    `PLS_ASSERT_NEXT(a_busy_on_work, ctrl.accept && !ctrl.clear && !ctrl.reject, busy,
        "accepted request did not raise busy")
    // Every walk step consumes exactly one position.
    `PLS_ASSERT_NEXT(a_walk_step, ctrl.walk_step, remain_reg == $past(remain_reg) - POS_W'(1),
        "walk step count mismatch")
    // The last cycle of a request yields one strobe and frees the block.
    `PLS_ASSERT_NEXT(a_finish, ctrl.link_b || ctrl.unlink || ctrl.read_out, done && !busy,
        "finished request gave no result")

endmodule

// ----- bench/positional_list_store_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Positional list store testbench
// Drives insert, remove, read and clear requests into the list store and
// checks every result against a queue-based model of the ordered list.
// ---------------------------------------------------------------------------
module positional_list_store_tb;
    import pls_pkg::*;

    // No progress for this many cycles means the block has hung. The slowest
    // correct request walks nearly the whole ring, and the driver's idle bursts
    // between requests are shorter still, so the limit leaves ample margin.
    localparam int STALL_LIMIT = 2000;

    // The last stretch of requests goes in back to back, with no idling.
    localparam int QUIET_TAIL = 150;

    // Cycles to wait after the last result, which covers a full ring walk.
    localparam int DRAIN_CYCLES = 300;

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    request_t request = '0;
    logic     done;
    result_t  result;

    // Requests waiting to be driven, and results waiting to come back.
    request_t request_backlog[$];
    result_t  awaited_results[$];

    // The list as it should stand inside the block, first element at index 0.
    logic signed [VAL_W-1:0] list_contents[$];

    // Element count that the request planner tracks while it builds the
    // stimulus, so that it can aim positions at the live part of the list.
    int planned_count = 0;
    int planned_total = 0;

    int sent_count     = 0;
    int gap_left       = 0;
    bit idle_mode      = 1'b1;
    int stall_cycles   = 0;
    int mismatch_count = 0;

    positional_list_store DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // List model. Applies one accepted request to the modeled list and
    // returns the result that the block must give for it. The ring links and
    // the free-slot stack inside the block are invisible from outside, so an
    // ordered queue of values carries everything that can be observed.
    // -----------------------------------------------------------------------
    function automatic result_t predict_list_result(request_t req);
        result_t res;
        int      pos;
        int      count;
        res.status     = ST_DONE;
        res.read_value = '0;
        pos            = int'(req.position);
        count          = list_contents.size();
        case (req.action)
            ACT_INSERT:
            begin
                // The position check comes before the fullness check.
                if (pos > count)
                    res.status = ST_RANGE;
                else if (count >= CAPACITY)
                    res.status = ST_FULL;
                else
                    list_contents.insert(pos, req.value);
            end
            ACT_REMOVE:
            begin
                if (pos >= count)
                    res.status = ST_RANGE;
                else
                    list_contents.delete(pos);
            end
            ACT_READ:
            begin
                if (pos >= count)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_contents[pos];
            end
            default:
            begin
                list_contents.delete();
            end
        endcase
        res.length = LEN_W'(list_contents.size());
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // -----------------------------------------------------------------------
    // Request planning. Every planned request also moves the planner's own
    // element count, so later requests can target positions that exist.
    // -----------------------------------------------------------------------
    task automatic plan_request(action_t act, int pos, logic [VAL_W-1:0] val);
        request_t req;
        req.action   = act;
        req.position = POS_W'(pos);
        req.value    = val;
        request_backlog.push_back(req);
        case (act)
            ACT_INSERT:
                if (pos <= planned_count && planned_count < CAPACITY)
                    planned_count++;
            ACT_REMOVE:
                if (pos < planned_count)
                    planned_count--;
            ACT_CLEAR:
                planned_count = 0;
            default:
                ;
        endcase
    endtask

    // Picks an action by weight, then a position: mostly inside the live
    // list, sometimes at its ends, one past the last valid one, or anywhere
    // in the nine-bit range.
    task automatic plan_random(int w_ins, int w_rem, int w_read, int w_clear);
        int      pick;
        int      roll;
        int      top;
        int      pos;
        action_t act;
        pick = $urandom_range(0, w_ins + w_rem + w_read + w_clear - 1);
        if (pick < w_ins)
            act = ACT_INSERT;
        else if (pick < w_ins + w_rem)
            act = ACT_REMOVE;
        else if (pick < w_ins + w_rem + w_read)
            act = ACT_READ;
        else
            act = ACT_CLEAR;
        // An insert may go at the count itself; other actions stop one short.
        top = (act == ACT_INSERT) ? planned_count : planned_count - 1;
        if (top < 0)
            top = 0;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            pos = $urandom_range(0, (1 << POS_W) - 1);
        else if (roll < 14)
            pos = 0;
        else if (roll < 20)
            pos = top;
        else if (roll < 24)
            pos = top + 1;
        else
            pos = $urandom_range(0, top);
        plan_request(act, pos, $urandom);
    endtask

    // -----------------------------------------------------------------------
    // Driver. A request is taken on an edge where start is high and busy is
    // low; at that edge the model is advanced and the expected result is
    // queued. Start stays high across busy cycles until the request is
    // taken. Between requests the driver may idle for a random burst, in
    // stretches that are picked at random as idling or back-to-back traffic.
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            request  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                awaited_results.push_back(predict_list_result(request));
                sent_count++;
                if (sent_count % 40 == 0)
                    idle_mode = $urandom_range(0, 1);
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (request_backlog.size() == 0)
                begin
                    start <= 1'b0;
                end
                else if (idle_mode && sent_count < planned_total - QUIET_TAIL
                         && $urandom_range(0, 4) == 0)
                begin
                    // This cycle is the first of the burst.
                    gap_left = $urandom_range(1, 14) - 1;
                    start <= 1'b0;
                end
                else
                begin
                    request <= request_backlog.pop_front();
                    start   <= 1'b1;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result checker. The receiver cannot hold results off, so every cycle
    // with done high carries one result, matched in order against the
    // oldest expectation.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_mismatch("result arrived with no request outstanding");
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.status !== want.status)
                    flag_mismatch($sformatf("status got %0d expected %0d",
                                            result.status, want.status));
                if (result.read_value !== want.read_value)
                    flag_mismatch($sformatf("read_value got %0d expected %0d",
                                            result.read_value, want.read_value));
                if (result.length !== want.length)
                    flag_mismatch($sformatf("length got %0d expected %0d",
                                            result.length, want.length));
            end
        end
    end

    // Watchdog: counts cycles in which neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus plan and end of run.
    // -----------------------------------------------------------------------
    initial
    begin
        // Directed opening: accesses on an empty list, inserts at the head,
        // in the middle and at the tail with extreme values, reads at both
        // ends and past the end, removes at every kind of position, and
        // clears of a populated and an empty list.
        plan_request(ACT_READ,   0,   32'h1234_5678);
        plan_request(ACT_REMOVE, 0,   32'h0);
        plan_request(ACT_INSERT, 1,   32'h0);
        plan_request(ACT_INSERT, 511, 32'hFFFF_FFFF);
        plan_request(ACT_INSERT, 0,   32'h7FFF_FFFF);
        plan_request(ACT_INSERT, 1,   32'h8000_0000);
        plan_request(ACT_INSERT, 0,   32'hFFFF_FFFF);
        plan_request(ACT_INSERT, 1,   32'h0000_0000);
        plan_request(ACT_INSERT, 4,   32'h5555_AAAA);
        plan_request(ACT_READ,   0,   32'h0);
        plan_request(ACT_READ,   4,   32'h0);
        plan_request(ACT_READ,   2,   32'h0);
        plan_request(ACT_READ,   5,   32'h0);
        plan_request(ACT_READ,   256, 32'h0);
        plan_request(ACT_REMOVE, 0,   32'h0);
        plan_request(ACT_REMOVE, 3,   32'h0);
        plan_request(ACT_REMOVE, 1,   32'h0);
        plan_request(ACT_REMOVE, 2,   32'h0);
        plan_request(ACT_CLEAR,  511, 32'hDEAD_BEEF);
        plan_request(ACT_READ,   0,   32'h0);
        plan_request(ACT_INSERT, 0,   32'hAAAA_5555);
        plan_request(ACT_REMOVE, 0,   32'h0);
        plan_request(ACT_CLEAR,  0,   32'h0);

        // Growth: mostly inserts, so the list reaches deep positions.
        repeat (300)
            plan_random(70, 10, 18, 0);

        // Fill to capacity, then poke at the full list: inserts report full
        // unless the position is past the count, and the last slot reads.
        while (planned_count < CAPACITY)
            plan_random(1, 0, 0, 0);
        plan_request(ACT_INSERT, CAPACITY,     $urandom);
        plan_request(ACT_INSERT, 0,            $urandom);
        plan_request(ACT_INSERT, CAPACITY + 1, $urandom);
        plan_request(ACT_READ,   CAPACITY - 1, $urandom);
        plan_request(ACT_READ,   CAPACITY,     $urandom);
        repeat (20)
            plan_random(3, 1, 2, 0);

        // Churn: balanced traffic with the odd clear.
        repeat (500)
            plan_random(40, 38, 20, 1);

        // Drain to empty, clear, and finish with mixed traffic.
        while (planned_count > 0)
            plan_random(0, 4, 1, 0);
        plan_request(ACT_CLEAR, 0, $urandom);
        repeat (100)
            plan_random(45, 30, 25, 0);

        planned_total = request_backlog.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request is taken and every result is back.
        @(negedge clk);
        while (request_backlog.size() != 0 || start || awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- positional_list_store.f -----
+incdir+sv
sv/pls_pkg.sv
sv/pls_ram.sv
sv/pls_seq.sv
sv/positional_list_store.sv
bench/positional_list_store_tb.sv
